FILE: rtl/core/rma_q15_pkg.sv
// ----------------------------------------------------------------------------
// rma_q15_pkg
// Shared constants for the recursive moving-average Q1.15 filter: window
// length, derived widths and configuration register indexes.
// ----------------------------------------------------------------------------
package rma_q15_pkg;

    localparam int WINDOW    = 4;
    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int GAIN_W    = 15;
    localparam int PROD_W    = SUM_W + GAIN_W + 1;
    localparam int FRAC_BITS = 15;
    localparam int Y_W       = PROD_W + 1 - FRAC_BITS;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8192);
    localparam logic [PROD_W:0]   BIAS_ROUND = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = CFG_IDX_W'(1);

endpackage

FILE: rtl/core/recursive_moving_average_q15_core.sv
// ----------------------------------------------------------------------------
// recursive_moving_average_q15_core
// Moving-average filter over the last WINDOW signed Q1.15 samples, with a
// running sum, unsigned Q0.15 gain, optional rounding and 16-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on s_valid/s_ready/s_sample; filtered items leave on
//   m_valid/m_ready/m_filtered. One item is taken per cycle when the output
//   side keeps up; each stage holds only while the stage after it is full.
//   The first WINDOW-1 samples fill the window and give no result; every
//   sample after that gives exactly one.
//   An accepted item passes stage 1, stage 2, stage 3 and the output register in turn.
//   Throughput: one item per cycle when the output side keeps up, set by the delay-line
//   memory, read for the leaving sample on acceptance, written as the item leaves stage 1.
//   cfg_we/cfg_index/cfg_wdata write round_mode (index 0) and gain (index 1); the user
//   must do so only while the block is idle, which the block itself does not enforce.
//   Reset (aresetn low at a clock edge) clears the window sum, fill count,
//   write pointer and all stage valids, and reloads round_mode = 1 and
//   gain = 8192. Memory entries not yet written read as zero via the fill
//   count, so no clearing pass is needed.
//   When m_ready is low the result holds on the port and the pipeline keeps
//   taking items until every stage is full.
// ----------------------------------------------------------------------------
module recursive_moving_average_q15_core
    import rma_q15_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_filtered,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(32768);

    logic                       round_mode_reg;
    logic [GAIN_W-1:0]          gain_reg;

    logic signed [SAMPLE_W-1:0] mem [WINDOW];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]           wr_pos_reg;
    logic [PTR_W-1:0]           wr_pos_next;
    logic [CNT_W-1:0]           fill_count_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [PTR_W-1:0]           s1_addr_reg;
    logic                       s1_old_ok_reg;
    logic                       s1_emit_reg;

    logic                       s2_valid_reg;
    logic signed [SUM_W-1:0]    s2_sum_reg;

    logic                       s3_valid_reg;
    logic signed [PROD_W-1:0]   s3_prod_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_filtered_reg;

    logic                       en1, en2, en3, en4;
    logic                       accept;
    logic                       s1_leave;
    logic signed [SUM_W-1:0]    old_sample;
    logic signed [PROD_W:0]     biased;
    logic signed [Y_W-1:0]      shifted;
    logic signed [SAMPLE_W-1:0] sat_next;

    assign en4      = !m_valid_reg || m_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_ready  = en1;
    assign accept   = s_valid && en1;
    assign s1_leave = s1_valid_reg && en2;

    assign wr_pos_next = (wr_pos_reg == PTR_W'(WINDOW - 1)) ? '0 : wr_pos_reg + PTR_W'(1);

    assign old_sample = s1_old_ok_reg ? SUM_W'(rd_data_reg) : '0;
    assign sum_next   = sum_reg + SUM_W'(s1_sample_reg) - old_sample;

    assign biased  = {s3_prod_reg[PROD_W-1], s3_prod_reg}
                   + (round_mode_reg ? BIAS_ROUND : '0);
    assign shifted = biased[PROD_W:FRAC_BITS];

    always_comb begin
        if (shifted > Y_MAX) begin
            sat_next = SAMPLE_W'(Y_MAX);
        end else if (shifted < Y_MIN) begin
            sat_next = SAMPLE_W'(Y_MIN);
        end else begin
            sat_next = shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_mode_reg <= 1'b1;
            gain_reg       <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROUND_MODE: round_mode_reg <= cfg_wdata[0];
                REG_GAIN:       gain_reg       <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // delay line: read the leaving sample on accept, write the new one as it leaves stage 1
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[wr_pos_reg];
        end
        if (s1_leave) begin
            mem[s1_addr_reg] <= s1_sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pos_reg     <= '0;
            fill_count_reg <= '0;
            sum_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                wr_pos_reg <= wr_pos_next;
                if (fill_count_reg != CNT_W'(WINDOW)) begin
                    fill_count_reg <= fill_count_reg + CNT_W'(1);
                end
            end
            if (en1) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_leave) begin
                sum_reg <= sum_next;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (en3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= s_sample;
            s1_addr_reg   <= wr_pos_reg;
            s1_old_ok_reg <= (fill_count_reg == CNT_W'(WINDOW));
            s1_emit_reg   <= (fill_count_reg >= CNT_W'(WINDOW - 1));
        end
        if (en2) begin
            s2_sum_reg <= sum_next;
        end
        if (en3) begin
            s3_prod_reg <= s2_sum_reg * $signed({1'b0, gain_reg});
        end
        if (en4 && s3_valid_reg) begin
            m_filtered_reg <= sat_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pos_reg <= PTR_W'(WINDOW - 1))
        else $error("write pointer beyond window");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> fill_count_reg == CNT_W'(WINDOW))
        else $error("result before window filled");

    a_emit_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_emit_reg) |-> fill_count_reg == CNT_W'(WINDOW))
        else $error("emit flag without full window");
`endif

endmodule

FILE: tb/rma_q15_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rma_q15_checker
// Watches the sample, result and register-write ports of the moving-average
// filter, keeps its own window, running sum and settings, predicts each
// filtered item and compares it with what leaves the block, in order.
// ----------------------------------------------------------------------------
module rma_q15_checker
    import rma_q15_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [SAMPLE_W-1:0]  m_filtered,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    output int                          mismatch_count,
    output int                          pending
);

    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W:0] OUT_MAX    = 32767;
    localparam logic signed [PROD_W:0] OUT_MIN    = -32768;

    logic signed [SAMPLE_W-1:0] taps [WINDOW];
    logic signed [SUM_W-1:0]    run_sum;
    int unsigned                tap_pos;
    int unsigned                taken;
    logic                       round_en;
    logic [GAIN_W-1:0]          gain_q15;

    logic signed [SAMPLE_W-1:0] filtered_expected [$];

    function automatic bit average_step(input logic signed [SAMPLE_W-1:0] smp,
                                        output logic signed [SAMPLE_W-1:0] avg);
        logic signed [PROD_W:0] scaled;
        run_sum = run_sum + smp - taps[tap_pos];
        taps[tap_pos] = smp;
        tap_pos = (tap_pos + 1 >= WINDOW) ? 0 : tap_pos + 1;
        if (taken < WINDOW)
            taken++;
        avg = '0;
        if (taken < WINDOW)
            return 1'b0;
        scaled = run_sum * $signed({1'b0, gain_q15});
        if (round_en)
            scaled = scaled + ROUND_HALF;
        scaled = scaled >>> FRAC_BITS;
        if (scaled > OUT_MAX)
            scaled = OUT_MAX;
        else if (scaled < OUT_MIN)
            scaled = OUT_MIN;
        avg = scaled[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        logic signed [SAMPLE_W-1:0] next_avg;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++)
                taps[i] = '0;
            run_sum  = '0;
            tap_pos  = 0;
            taken    = 0;
            round_en = 1'b1;
            gain_q15 = GAIN_W'(8192);
            filtered_expected.delete();
            mismatch_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROUND_MODE: round_en = cfg_wdata[0];
                    REG_GAIN:       gain_q15 = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // check results before queueing, the block never answers in the same cycle
            if (m_valid && m_ready) begin
                if (filtered_expected.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0d",
                             $time, m_filtered);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = filtered_expected.pop_front();
                    if (m_filtered !== want) begin
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, want, m_filtered);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (average_step(s_sample, next_avg))
                    filtered_expected.push_back(next_avg);
            end
        end
        pending <= filtered_expected.size();
    end

endmodule

FILE: tb/tb_recursive_moving_average_q15_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_recursive_moving_average_q15_core
// Drives samples through the moving-average filter in bursts under a
// randomly stalling receiver, across several rounding and gain settings,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_recursive_moving_average_q15_core;
    import rma_q15_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_ITEMS     = 300;
    localparam int NUM_PHASES      = 6;
    localparam int HOLDOFF_AT      = 700;
    localparam int HOLDOFF_CYCLES  = 150;

    logic                       aclk       = 1'b0;
    logic                       aresetn    = 1'b0;
    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample   = '0;
    logic                       m_valid;
    logic                       m_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] m_filtered;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = REG_ROUND_MODE;
    logic [CFG_DATA_W-1:0]      cfg_wdata  = '0;

    int mismatch_count;
    int pending;
    int samples_taken = 0;
    int cycle_count   = 0;

    int ready_mode    = 0;
    int mode_left     = 0;
    int holdoff_left  = 0;
    bit holdoff_done  = 1'b0;

    recursive_moving_average_q15_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    rma_q15_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_filtered     (m_filtered),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** recursive_moving_average_q15_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stretches of readiness, one long hold-off to fill the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            m_ready      <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && samples_taken >= HOLDOFF_AT) begin
            m_ready      <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        samples_taken++;
    endtask

    // round_mode data carries random upper bits that must be dropped
    task automatic write_settings(input bit rnd, input logic [GAIN_W-1:0] g);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROUND_MODE;
        cfg_wdata <= CFG_DATA_W'({$urandom(), rnd});
        @(posedge aclk);
        cfg_index <= REG_GAIN;
        cfg_wdata <= CFG_DATA_W'(g);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // wait for a clock edge first so the count includes the item just accepted
    task automatic wait_idle();
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        bit                rnd;
        logic [GAIN_W-1:0] g;
        int                sent;
        int                burst;
        int                gap;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: window fill, full scale both ways, rounding of small values
        repeat (4) send_sample(16'sh7fff);
        repeat (4) send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        s_valid <= 1'b0;
        wait_idle();

        // truncation with maximum gain: saturation both ways, floor of negatives
        write_settings(1'b0, 15'h7fff);
        repeat (3) send_sample(16'sh8000);
        repeat (4) send_sample(16'sh7fff);
        send_sample(16'shffff);
        send_sample(16'sh0001);
        send_sample(16'shfffe);
        s_valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin rnd = 1'b0; g = 15'h0000; end
                1:       begin rnd = 1'b1; g = 15'h7fff; end
                2:       begin rnd = 1'b0; g = 15'h0001; end
                3:       begin rnd = 1'b1; g = GAIN_W'(8192); end
                default: begin rnd = 1'($urandom_range(0, 1)); g = GAIN_W'($urandom()); end
            endcase
            write_settings(rnd, g);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_sample(pick_sample());
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_valid <= 1'b0;
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("** recursive_moving_average_q15_core: PASSED **");
        else
            $display("** recursive_moving_average_q15_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rma_q15_pkg.sv
rtl/core/recursive_moving_average_q15_core.sv
tb/rma_q15_checker.sv
tb/tb_recursive_moving_average_q15_core.sv
